>>> hdl/matrix_inverse_3x3_defines.svh
// Assertion macros for the 3x3 matrix inverse.
// Used by matrix_inverse_3x3.sv; expects clk_i and rst_ni in scope.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// checked only out of reset
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/mi3_pkg.sv
// Shared widths, latencies and lane control type for the 3x3 matrix inverse.
// No dependencies.
package mi3_pkg;
  localparam int unsigned DW      = 32;          // entry and result width
  localparam int unsigned CW      = 64;          // cofactor width
  localparam int unsigned MW      = 97;          // determinant width
  localparam int unsigned QB      = DW;          // quotient bits, one per stage
  localparam int unsigned FRONT   = 6;           // stages up to |det|
  localparam int unsigned LANE_LAT = QB + 2;     // setup, quotient steps, saturate
  localparam int unsigned LAT     = FRONT + LANE_LAT;

  typedef struct packed {
    logic neg;   // result sign
    logic ovf;   // quotient at least 2^32
    logic sing;  // zero determinant
  } lane_ctl_t;
endpackage

>>> hdl/mi3_div.sv
// One division lane: |cof| * 2^32 / |det|, one quotient bit per stage, then
// sign and saturation. Depends on mi3_pkg.
module mi3_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [mi3_pkg::CW-1:0]    cm_i,
  input  logic [mi3_pkg::MW-1:0]    dmag_i,
  input  logic                      neg_i,
  input  logic                      sing_i,
  output logic signed [mi3_pkg::DW-1:0] val_o,
  output logic                      sing_o
);
  localparam int unsigned MW = mi3_pkg::MW;
  localparam int unsigned QB = mi3_pkg::QB;
  localparam int unsigned DW = mi3_pkg::DW;

  logic [MW-1:0]      r_q    [QB+1];
  logic [QB-1:0]      qt_q   [QB+1];
  logic [MW-1:0]      dmag_q [QB+1];
  mi3_pkg::lane_ctl_t ctl_q  [QB+1];
  logic [DW-1:0]      val_q, val_d;
  logic               sing_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]         <= MW'(cm_i);
      qt_q[0]        <= '0;
      dmag_q[0]      <= dmag_i;
      ctl_q[0].neg   <= neg_i;
      ctl_q[0].sing  <= sing_i;
      ctl_q[0].ovf   <= MW'(cm_i) >= dmag_i;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [MW:0]   rs;
    logic [MW:0]   df;
    logic          ge;
    assign rs = {r_q[s], 1'b0};
    assign df = rs - {1'b0, dmag_q[s]};
    assign ge = rs >= {1'b0, dmag_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]    <= ge ? df[MW-1:0] : rs[MW-1:0];
        qt_q[s+1]   <= {qt_q[s][QB-2:0], ge};
        dmag_q[s+1] <= dmag_q[s];
        ctl_q[s+1]  <= ctl_q[s];
      end
    end
  end

  always_comb begin
    mi3_pkg::lane_ctl_t c;
    logic [QB-1:0]      q;
    c = ctl_q[QB];
    q = qt_q[QB];
    if (c.sing) begin
      val_d = '0;
    end else if (c.neg) begin
      if (c.ovf || q > {1'b1, {(QB-1){1'b0}}}) begin
        val_d = {1'b1, {(DW-1){1'b0}}};
      end else begin
        val_d = DW'(~q + 1'b1);
      end
    end else begin
      if (c.ovf || q[QB-1]) begin
        val_d = {1'b0, {(DW-1){1'b1}}};
      end else begin
        val_d = DW'(q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_d;
      sing_q <= ctl_q[QB].sing;
    end
  end

  assign val_o  = signed'(val_q);
  assign sing_o = sing_q;
endmodule

>>> hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate, signed Q16.16 in and out; uses mi3_pkg,
// mi3_div and matrix_inverse_3x3_defines.svh. A new matrix word is taken every
// cycle unless the output stalls; each result passes 6 stages of products,
// cofactors and determinant, then 32 restoring-division stages, one quotient
// bit each, plus setup and saturation stages in each of nine lanes.
// A stall on the output freezes the whole pipeline; stall_o follows stall_i
// while a result waits. A zero determinant sets singular_o and zeroes all
// entries; quotients out of range saturate.
`include "matrix_inverse_3x3_defines.svh"
module matrix_inverse_3x3 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] m00_i, m01_i, m02_i,
  input  logic signed [31:0] m10_i, m11_i, m12_i,
  input  logic signed [31:0] m20_i, m21_i, m22_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] inv00_o, inv01_o, inv02_o,
  output logic signed [31:0] inv10_o, inv11_o, inv12_o,
  output logic signed [31:0] inv20_o, inv21_o, inv22_o,
  output logic               singular_o
);
  localparam int unsigned DW  = mi3_pkg::DW;
  localparam int unsigned CW  = mi3_pkg::CW;
  localparam int unsigned MW  = mi3_pkg::MW;
  localparam int unsigned LAT = mi3_pkg::LAT;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en      = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  logic signed [DW-1:0] a [9];
  assign a = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  // stage 1: cofactor products
  logic signed [CW-1:0] pa_q [9], pb_q [9];
  logic signed [DW-1:0] a1_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= a[4] * a[8];  pb_q[0] <= a[5] * a[7];
      pa_q[1] <= a[2] * a[7];  pb_q[1] <= a[1] * a[8];
      pa_q[2] <= a[1] * a[5];  pb_q[2] <= a[2] * a[4];
      pa_q[3] <= a[5] * a[6];  pb_q[3] <= a[3] * a[8];
      pa_q[4] <= a[0] * a[8];  pb_q[4] <= a[2] * a[6];
      pa_q[5] <= a[2] * a[3];  pb_q[5] <= a[0] * a[5];
      pa_q[6] <= a[3] * a[7];  pb_q[6] <= a[4] * a[6];
      pa_q[7] <= a[1] * a[6];  pb_q[7] <= a[0] * a[7];
      pa_q[8] <= a[0] * a[4];  pb_q[8] <= a[1] * a[3];
      a1_q    <= '{a[0], a[1], a[2]};
    end
  end

  // stage 2: cofactors
  logic signed [CW-1:0] c2_q [9];
  logic signed [DW-1:0] a2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) c2_q[k] <= pa_q[k] - pb_q[k];
      a2_q <= a1_q;
    end
  end

  // stage 3: split products of first-column cofactors with first row
  logic signed [CW-1:0]   ph_q [3];
  logic signed [CW:0]     pl_q [3];
  logic signed [CW-1:0]   c3_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ph_q[j] <= signed'(c2_q[3*j][CW-1:DW]) * a2_q[j];
        pl_q[j] <= signed'({1'b0, c2_q[3*j][DW-1:0]}) * a2_q[j];
      end
      c3_q <= c2_q;
    end
  end

  // stage 4: recombine
  logic signed [MW-1:0] t_q [3];
  logic signed [CW-1:0] c4_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        t_q[j] <= (MW'(ph_q[j]) <<< DW) + MW'(pl_q[j]);
      end
      c4_q <= c3_q;
    end
  end

  // stage 5: determinant
  logic signed [MW-1:0] det_q;
  logic signed [CW-1:0] c5_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= t_q[0] + t_q[1] + t_q[2];
      c5_q  <= c4_q;
    end
  end

  // stage 6: magnitudes and signs
  logic [MW-1:0] dmag_q;
  logic          zero_q;
  logic [CW-1:0] cm_q [9];
  logic [8:0]    neg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q <= det_q[MW-1] ? MW'(-det_q) : MW'(det_q);
      zero_q <= det_q == '0;
      for (int k = 0; k < 9; k++) begin
        cm_q[k]  <= c5_q[k][CW-1] ? CW'(-c5_q[k]) : CW'(c5_q[k]);
        neg_q[k] <= c5_q[k][CW-1] ^ det_q[MW-1];
      end
    end
  end

  logic signed [DW-1:0] inv [9];
  logic [8:0]           sing;
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .cm_i   (cm_q[k]),
      .dmag_i (dmag_q),
      .neg_i  (neg_q[k]),
      .sing_i (zero_q),
      .val_o  (inv[k]),
      .sing_o (sing[k])
    );
  end

  assign inv00_o = inv[0];  assign inv01_o = inv[1];  assign inv02_o = inv[2];
  assign inv10_o = inv[3];  assign inv11_o = inv[4];  assign inv12_o = inv[5];
  assign inv20_o = inv[6];  assign inv21_o = inv[7];  assign inv22_o = inv[8];
  assign singular_o = sing[0];

  `MI3_ASSERT_ALWAYS(a_stall_map, stall_o == (valid_o && stall_i), "stall_o mismatch")
  `MI3_ASSERT(a_sing_zero, (valid_o && singular_o) |-> (inv00_o == 0 && inv11_o == 0 && inv22_o == 0), "singular result not zero")
  `MI3_ASSERT(a_sing_lanes, valid_o |-> (sing == '0 || sing == '1), "lanes disagree on singular")
  `MI3_ASSERT(a_hold, (valid_o && stall_i) |=> (valid_o && $stable(inv12_o) && $stable(singular_o)), "stalled word changed")
endmodule

>>> tb/sv/matrix_inverse_3x3_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_inverse_3x3: a directed table, then random matrices.
// Each accepted word is checked against an adjugate predictor. Depends on mi3_pkg
// and the RTL.
module matrix_inverse_3x3_tb;
  localparam int unsigned DW  = mi3_pkg::DW;
  localparam int unsigned LAT = mi3_pkg::LAT;

  typedef struct packed {
    logic [8:0][DW-1:0] inv;
    logic               sing;
  } inv_res_t;

  typedef struct packed {
    logic [8:0][DW-1:0] m;
    logic               typed;
    inv_res_t           res;
  } mat_row_t;

  localparam logic [DW-1:0] ONE  = 32'h0001_0000;
  localparam logic [DW-1:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SMIN = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, singular_o;
  logic [8:0][DW-1:0] mat_drv = '0;
  logic signed [31:0] inv00_o, inv01_o, inv02_o, inv10_o, inv11_o, inv12_o;
  logic signed [31:0] inv20_o, inv21_o, inv22_o;
  inv_res_t cur_res = '0;

  inv_res_t inv_expected_q[$];
  mat_row_t dir_q[$];
  int       n_fail = 0;
  bit       hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  matrix_inverse_3x3 dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .m00_i(mat_drv[0]), .m01_i(mat_drv[1]), .m02_i(mat_drv[2]),
    .m10_i(mat_drv[3]), .m11_i(mat_drv[4]), .m12_i(mat_drv[5]),
    .m20_i(mat_drv[6]), .m21_i(mat_drv[7]), .m22_i(mat_drv[8]),
    .valid_o, .stall_i,
    .inv00_o, .inv01_o, .inv02_o, .inv10_o, .inv11_o, .inv12_o,
    .inv20_o, .inv21_o, .inv22_o, .singular_o
  );

  function automatic inv_res_t inv_predict(input logic [8:0][DW-1:0] a);
    longint v[9];
    longint c[9];
    logic signed [127:0] det, ci;
    logic [127:0] dmag, cmag, q;
    logic dneg, neg;
    inv_res_t r;
    r = '0;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(a[i]));
    c[0] = v[4] * v[8] - v[5] * v[7];
    c[1] = v[2] * v[7] - v[1] * v[8];
    c[2] = v[1] * v[5] - v[2] * v[4];
    c[3] = v[5] * v[6] - v[3] * v[8];
    c[4] = v[0] * v[8] - v[2] * v[6];
    c[5] = v[2] * v[3] - v[0] * v[5];
    c[6] = v[3] * v[7] - v[4] * v[6];
    c[7] = v[1] * v[6] - v[0] * v[7];
    c[8] = v[0] * v[4] - v[1] * v[3];
    det = 128'(signed'(c[0])) * 128'(signed'(v[0])) + 128'(signed'(c[3])) * 128'(signed'(v[1]))
        + 128'(signed'(c[6])) * 128'(signed'(v[2]));
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dneg = det[127];
    dmag = dneg ? -det : det;
    for (int i = 0; i < 9; i++) begin
      ci = 128'(signed'(c[i]));
      cmag = ci[127] ? -ci : ci;
      neg = ci[127] ^ dneg;
      q = (cmag << 32) / dmag;
      if (neg) r.inv[i] = (q > 128'h8000_0000) ? SMIN : DW'(-q);
      else r.inv[i] = (q > 128'h7FFF_FFFF) ? SMAX : q[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [8:0][DW-1:0] diag3(input logic [DW-1:0] x, y, z);
    logic [8:0][DW-1:0] m;
    m = '0;
    m[0] = x;
    m[4] = y;
    m[8] = z;
    return m;
  endfunction

  task automatic add_row(input logic [8:0][DW-1:0] m, input bit typed,
                         input inv_res_t res);
    mat_row_t r;
    r.m = m;
    r.typed = typed;
    r.res = res;
    dir_q.push_back(r);
  endtask

  function automatic logic [DW-1:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return SMAX;
      4: return SMIN;
      default: return ONE;
    endcase
  endfunction

  function automatic logic [8:0][DW-1:0] rand_matrix();
    logic [8:0][DW-1:0] m;
    int k, s;
    k = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (k < 40) m[i] = DW'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      else if (k < 60) m[i] = $urandom;
      else if (k < 75) m[i] = DW'($signed($urandom_range(0, 16)) - 8);
      else m[i] = pick_edge();
    end
    if (k < 40 && $urandom_range(0, 1)) begin
      m[0] = m[0] + 32'h8_0000;
      m[4] = m[4] + 32'h8_0000;
      m[8] = m[8] + 32'h8_0000;
    end
    if ($urandom_range(0, 99) < 15) begin
      s = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0: for (int j = 0; j < 3; j++) m[3 * ((s + 1) % 3) + j] = m[3 * s + j];
        1: for (int j = 0; j < 3; j++) m[3 * s + j] = '0;
        default: for (int j = 0; j < 3; j++) m[3 * j + s] = m[3 * j + (s + 2) % 3];
      endcase
    end
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got, exp_v);
    n_fail++;
    $display("mismatch %s: got %h exp %h at %0t", what, got, exp_v, $realtime);
  endtask

  // result checker
  always @(posedge clk_i) begin
    inv_res_t e;
    logic [8:0][DW-1:0] got;
    if (rst_ni && valid_o && !stall_i) begin
      got = {inv22_o, inv21_o, inv20_o, inv12_o, inv11_o, inv10_o, inv02_o, inv01_o, inv00_o};
      if (inv_expected_q.size() == 0) begin
        report_mismatch("unexpected word", got[0], '0);
      end else begin
        e = inv_expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.inv[i]) report_mismatch($sformatf("inv%0d", i), got[i], e.inv[i]);
        if (singular_o !== e.sing) report_mismatch("singular", singular_o, e.sing);
      end
    end
  end

  // input acceptance
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      inv_expected_q.push_back(cur_res);
    end
  end

  // receiver
  initial begin
    int hold;
    int calm;
    calm = 0;
    @(posedge rst_ni);
    forever begin
      if (calm > 0) begin
        calm--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 18);
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // sender
  initial begin
    mat_row_t r;
    logic [8:0][DW-1:0] m;
    inv_res_t zr, ir, p;
    int gap, calm, total;
    bit held;
    zr = '0;
    zr.sing = 1'b1;
    add_row('0, 1, zr);
    add_row({9{SMIN}}, 1, zr);
    add_row({9{SMAX}}, 1, zr);
    add_row({9{32'hFFFF_FFFF}}, 1, zr);
    ir = '0;
    ir.inv = diag3(ONE, ONE, ONE);
    add_row(diag3(ONE, ONE, ONE), 1, ir);
    ir.inv = diag3(32'h8000, 32'h8000, 32'h8000);
    add_row(diag3(32'h2_0000, 32'h2_0000, 32'h2_0000), 1, ir);
    ir.inv = diag3(SMAX, SMAX, SMAX);
    add_row(diag3(32'd1, 32'd1, 32'd1), 1, ir);
    ir.inv = diag3(SMIN, SMIN, SMIN);
    add_row(diag3('1, '1, '1), 1, ir);
    add_row(diag3(SMAX, SMAX, SMAX), 0, zr);
    add_row(diag3(SMIN, SMIN, SMIN), 0, zr);
    add_row(diag3(SMIN, ONE, ONE), 0, zr);
    add_row(diag3(-32'sd2, 32'd1, 32'd1), 0, zr);
    add_row(diag3(SMAX, SMIN, 32'd3), 0, zr);
    m = '0;
    m[1] = ONE;
    m[5] = ONE;
    m[6] = ONE;
    add_row(m, 0, zr);
    m = {32'd0, 32'h6_0000, 32'h5_0000, 32'h4_0000, ONE, 32'd0,
         32'h3_0000, 32'h2_0000, ONE};
    add_row(m, 0, zr);
    m = {32'hFFFF_0000, 32'h1234_5678, SMIN, 32'h0003_0000, SMAX, 32'hFFFE_0000,
         32'd7, 32'h8765_4321, 32'h0001_8000};
    add_row(m, 0, zr);
    m = {SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 32'd0};
    add_row(m, 0, zr);

    total = dir_q.size() + 1600;
    calm = 0;
    held = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < total; n++) begin
      if (n < dir_q.size()) begin
        r = dir_q[n];
        p = r.typed ? r.res : inv_predict(r.m);
        if (r.typed && p !== inv_predict(r.m)) report_mismatch("table row", DW'(n), '0);
        m = r.m;
      end else begin
        m = rand_matrix();
        p = inv_predict(m);
      end
      if (!held && n == 700) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 100);
      end
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      valid_i <= 1'b1;
      mat_drv <= m;
      cur_res <= p;
      do @(posedge clk_i); while (stall_o);
    end
    valid_i <= 1'b0;
    while (inv_expected_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 20) @(posedge clk_i);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
